// ----- rtl/core/dobs_pkg.sv -----
package dobs_pkg;

	localparam int MAX_STEPS = 16;
	localparam int DUR_W     = 24;
	localparam int IDX_W     = $clog2(MAX_STEPS);
	localparam int CNT_W     = IDX_W + 1;

	typedef enum logic [2:0] {
		ACT_SET     = 3'd0,
		ACT_IMPULSE = 3'd1,
		ACT_BEGIN   = 3'd2,
		ACT_ADD     = 3'd3,
		ACT_RUN     = 3'd4,
		ACT_TICK    = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		TOK_TIMED = 2'd0,
		TOK_HOLD  = 2'd1,
		TOK_LOOP  = 2'd2
	} token_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'b001,
		MODE_IMPULSE = 3'b010,
		MODE_PATTERN = 3'b100
	} mode_t;

	typedef struct packed {
		logic [2:0]       action;
		logic             level;
		logic [1:0]       token_kind;
		logic [DUR_W-1:0] duration;
	} cmd_t;

	typedef struct packed {
		logic             out_level;
		logic             write_strobe;
		logic             busy_res;
		logic             table_full;
	} result_t;

	typedef struct packed {
		logic             lvl;
		logic [DUR_W-1:0] ticks;
	} step_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		step_t            data;
	} step_wr_t;

endpackage

// ----- rtl/core/dobs_in_if.sv -----
interface dobs_in_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  action;
	logic                        level;
	logic [1:0]                  token_kind;
	logic [dobs_pkg::DUR_W-1:0]  duration;

	modport source (output valid, action, level, token_kind, duration, input ready);
	modport sink (input valid, action, level, token_kind, duration, output ready);
endinterface

// ----- rtl/core/dobs_out_if.sv -----
interface dobs_out_if;
	logic valid;
	logic ready;
	logic out_level;
	logic write_strobe;
	logic busy_res;
	logic table_full;

	modport source (output valid, out_level, write_strobe, busy_res, table_full, input ready);
	modport sink (input valid, out_level, write_strobe, busy_res, table_full, output ready);
endinterface

// ----- rtl/core/dobs_step_table.sv -----
module dobs_step_table (
	input  logic                            clk,
	input  dobs_pkg::step_wr_t              wr,
	input  logic [dobs_pkg::IDX_W-1:0]      rd_addr,
	output dobs_pkg::step_t                 rd_data
);

	dobs_pkg::step_t steps_q [dobs_pkg::MAX_STEPS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			steps_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = steps_q[rd_addr];

endmodule

// ----- rtl/core/dobs_engine.sv -----
module dobs_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  dobs_pkg::cmd_t              cmd,
	input  dobs_pkg::step_t             rd_data,
	output logic [dobs_pkg::IDX_W-1:0]  rd_addr,
	output dobs_pkg::step_wr_t          wr,
	output dobs_pkg::result_t           res
);

	localparam logic [dobs_pkg::CNT_W-1:0] MaxCnt = dobs_pkg::CNT_W'(dobs_pkg::MAX_STEPS);

	logic                        drive_q, n_drive;
	dobs_pkg::mode_t             mode_q, n_mode;
	logic [dobs_pkg::DUR_W-1:0]  ticks_q, n_ticks;
	logic [dobs_pkg::CNT_W-1:0]  index_q, n_index;
	logic [dobs_pkg::CNT_W-1:0]  total_q, n_total;
	logic [dobs_pkg::CNT_W-1:0]  loop_pt_q, n_loop_pt;
	logic                        loop_seen_q, n_loop_seen;
	logic                        next_lvl_q, n_next_lvl;

	logic [dobs_pkg::CNT_W-1:0]  nxt;
	logic                        wrap;
	logic                        expire;
	logic                        strobe;
	logic                        full;

	assign wrap = (total_q != '0) && (index_q == total_q - 1'b1) && loop_seen_q
		&& (loop_pt_q < total_q);
	assign nxt = wrap ? loop_pt_q : index_q + 1'b1;
	assign expire = (ticks_q <= dobs_pkg::DUR_W'(1));
	assign rd_addr = (cmd.action == dobs_pkg::ACT_RUN) ? '0 : nxt[dobs_pkg::IDX_W-1:0];

	always_comb begin
		n_drive     = drive_q;
		n_mode      = mode_q;
		n_ticks     = ticks_q;
		n_index     = index_q;
		n_total     = total_q;
		n_loop_pt   = loop_pt_q;
		n_loop_seen = loop_seen_q;
		n_next_lvl  = next_lvl_q;
		strobe      = 1'b0;
		full        = 1'b0;
		wr          = '0;
		case (dobs_pkg::action_t'(cmd.action))
			dobs_pkg::ACT_SET: begin
				n_mode  = dobs_pkg::MODE_IDLE;
				n_ticks = '0;
				n_drive = cmd.level;
				strobe  = 1'b1;
			end
			dobs_pkg::ACT_IMPULSE: begin
				n_drive = 1'b1;
				strobe  = 1'b1;
				n_mode  = dobs_pkg::MODE_IMPULSE;
				n_ticks = cmd.duration;
			end
			dobs_pkg::ACT_BEGIN: begin
				n_mode      = dobs_pkg::MODE_IDLE;
				n_ticks     = '0;
				n_total     = '0;
				n_index     = '0;
				n_loop_pt   = '0;
				n_loop_seen = 1'b0;
				n_next_lvl  = 1'b1;
			end
			dobs_pkg::ACT_ADD: begin
				if (cmd.token_kind inside {dobs_pkg::TOK_TIMED, dobs_pkg::TOK_HOLD}) begin
					if (total_q < MaxCnt) begin
						wr.en   = fire;
						wr.addr = total_q[dobs_pkg::IDX_W-1:0];
						if (cmd.token_kind == dobs_pkg::TOK_TIMED) begin
							wr.data.lvl   = next_lvl_q;
							wr.data.ticks = cmd.duration;
							n_next_lvl    = ~next_lvl_q;
						end else begin
							wr.data.lvl   = drive_q;
							wr.data.ticks = '0;
						end
						n_total = total_q + 1'b1;
					end else begin
						full = 1'b1;
					end
				end else if (cmd.token_kind == dobs_pkg::TOK_LOOP) begin
					if (!loop_seen_q) begin
						n_loop_seen = 1'b1;
						n_loop_pt   = total_q;
					end
				end
			end
			dobs_pkg::ACT_RUN: begin
				n_mode  = dobs_pkg::MODE_IDLE;
				n_ticks = '0;
				n_index = '0;
				if (total_q != '0) begin
					n_drive = rd_data.lvl;
					n_ticks = rd_data.ticks;
					n_mode  = dobs_pkg::MODE_PATTERN;
					strobe  = 1'b1;
				end
			end
			dobs_pkg::ACT_TICK: begin
				if (mode_q == dobs_pkg::MODE_IMPULSE) begin
					if (expire) begin
						n_mode  = dobs_pkg::MODE_IDLE;
						n_ticks = '0;
						n_drive = 1'b0;
						strobe  = 1'b1;
					end else begin
						n_ticks = ticks_q - 1'b1;
					end
				end else if (mode_q == dobs_pkg::MODE_PATTERN) begin
					if (expire) begin
						if (nxt < total_q) begin
							n_index = nxt;
							n_drive = rd_data.lvl;
							n_ticks = rd_data.ticks;
							strobe  = 1'b1;
						end else begin
							n_mode  = dobs_pkg::MODE_IDLE;
							n_ticks = '0;
						end
					end else begin
						n_ticks = ticks_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign res.out_level    = n_drive;
	assign res.write_strobe = strobe;
	assign res.busy_res     = (n_mode != dobs_pkg::MODE_IDLE);
	assign res.table_full   = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q     <= 1'b0;
			mode_q      <= dobs_pkg::MODE_IDLE;
			ticks_q     <= '0;
			index_q     <= '0;
			total_q     <= '0;
			loop_pt_q   <= '0;
			loop_seen_q <= 1'b0;
			next_lvl_q  <= 1'b1;
		end else if (fire) begin
			drive_q     <= n_drive;
			mode_q      <= n_mode;
			ticks_q     <= n_ticks;
			index_q     <= n_index;
			total_q     <= n_total;
			loop_pt_q   <= n_loop_pt;
			loop_seen_q <= n_loop_seen;
			next_lvl_q  <= n_next_lvl;
		end
	end

endmodule

// ----- rtl/core/digital_output_blink_sequencer.sv -----
// Channel  Direction  Payload
// item     in         action, level, token_kind, duration
// result   out        out_level, write_strobe, busy_res, table_full
//
// Every beat passes an input register and then a result register, and one beat is
// taken per cycle while the result register is not stalled.
// The state update and the single step-table read both happen in the same cycle.
// Reset clears the control state; the step table holds no reset value.
// A stalled result holds its register, and the input register then fills and stalls the input.
module digital_output_blink_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	dobs_in_if.sink    item,
	dobs_out_if.source result
);

	logic                           valid_s1;
	dobs_pkg::cmd_t                 cmd_s1;
	logic                           res_valid_q;
	dobs_pkg::result_t              res_q;
	logic                           advance;
	logic                           accept;
	logic                           fire;
	dobs_pkg::result_t              res;
	dobs_pkg::step_wr_t             wr;
	dobs_pkg::step_t                rd_data;
	logic [dobs_pkg::IDX_W-1:0]     rd_addr;

	assign advance    = !res_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign accept     = item.valid && item.ready;
	assign fire       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.action     <= item.action;
			cmd_s1.level      <= item.level;
			cmd_s1.token_kind <= item.token_kind;
			cmd_s1.duration   <= item.duration;
		end
		if (fire) begin
			res_q <= res;
		end
	end

	dobs_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.cmd     (cmd_s1),
		.rd_data (rd_data),
		.rd_addr (rd_addr),
		.wr      (wr),
		.res     (res)
	);

	dobs_step_table u_table (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign result.valid        = res_valid_q;
	assign result.out_level    = res_q.out_level;
	assign result.write_strobe = res_q.write_strobe;
	assign result.busy_res     = res_q.busy_res;
	assign result.table_full   = res_q.table_full;

endmodule

// ----- tb/digital_output_blink_sequencer_tb.sv -----
module digital_output_blink_sequencer_tb;
	import dobs_pkg::*;

	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;
	localparam logic [1:0] TOK_SPARE   = 2'd3;
	localparam int         STALL_LEN   = 150;

	logic clk = 1'b0;
	logic arst_n;

	dobs_in_if  item_ch ();
	dobs_out_if result_ch ();

	digital_output_blink_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the sequencer state.
	logic             drv_level;
	mode_t            play_mode;
	logic [DUR_W-1:0] ticks_left;
	logic [IDX_W-1:0] cur_step;
	step_t            step_table [MAX_STEPS];
	logic [CNT_W-1:0] step_count;
	logic [CNT_W-1:0] loop_at;
	logic             loop_armed;
	logic             next_high;

	cmd_t    pending_cmds [$];
	result_t expected_results [$];
	cmd_t    next_cmd;

	int queued         = 0;
	int items_done     = 0;
	int checked        = 0;
	int errors         = 0;
	int writes_seen    = 0;
	int drops_seen     = 0;
	int steps_entered  = 0;
	int send_idle      = 0;
	int recv_idle      = 0;
	int stall_left     = 0;
	bit stall_arm      = 1'b0;
	bit stall_done     = 1'b0;

	function automatic void load_step(int i);
		cur_step   = i[IDX_W-1:0];
		drv_level  = step_table[i].lvl;
		ticks_left = step_table[i].ticks;
		play_mode  = MODE_PATTERN;
		steps_entered++;
	endfunction

	function automatic result_t blink_predict(cmd_t c);
		result_t r;
		logic    strobe;
		logic    full;
		int      nxt;
		strobe = 1'b0;
		full   = 1'b0;
		case (c.action)
			ACT_SET: begin
				play_mode  = MODE_IDLE;
				ticks_left = '0;
				drv_level  = c.level;
				strobe     = 1'b1;
			end
			ACT_IMPULSE: begin
				drv_level  = 1'b1;
				strobe     = 1'b1;
				play_mode  = MODE_IMPULSE;
				ticks_left = c.duration;
			end
			ACT_BEGIN: begin
				play_mode  = MODE_IDLE;
				ticks_left = '0;
				step_count = '0;
				cur_step   = '0;
				loop_at    = '0;
				loop_armed = 1'b0;
				next_high  = 1'b1;
			end
			ACT_ADD: begin
				if (c.token_kind == TOK_TIMED || c.token_kind == TOK_HOLD) begin
					if (int'(step_count) < MAX_STEPS) begin
						if (c.token_kind == TOK_TIMED) begin
							step_table[step_count].lvl   = next_high;
							step_table[step_count].ticks = c.duration;
							next_high = ~next_high;
						end else begin
							step_table[step_count].lvl   = drv_level;
							step_table[step_count].ticks = '0;
						end
						step_count++;
					end else begin
						full = 1'b1;
					end
				end else if (c.token_kind == TOK_LOOP) begin
					if (!loop_armed) begin
						loop_armed = 1'b1;
						loop_at    = step_count;
					end
				end
			end
			ACT_RUN: begin
				play_mode  = MODE_IDLE;
				ticks_left = '0;
				cur_step   = '0;
				if (step_count != 0) begin
					load_step(0);
					strobe = 1'b1;
				end
			end
			ACT_TICK: begin
				if (play_mode == MODE_IMPULSE) begin
					if (ticks_left <= 1) begin
						play_mode  = MODE_IDLE;
						ticks_left = '0;
						drv_level  = 1'b0;
						strobe     = 1'b1;
					end else begin
						ticks_left--;
					end
				end else if (play_mode == MODE_PATTERN) begin
					if (ticks_left <= 1) begin
						nxt = int'(cur_step) + 1;
						if (step_count != 0 && int'(cur_step) == int'(step_count) - 1 &&
						    loop_armed && loop_at < step_count)
							nxt = int'(loop_at);
						if (nxt < int'(step_count)) begin
							load_step(nxt);
							strobe = 1'b1;
						end else begin
							play_mode  = MODE_IDLE;
							ticks_left = '0;
						end
					end else begin
						ticks_left--;
					end
				end
			end
			default: begin
			end
		endcase
		if (strobe)
			writes_seen++;
		if (full)
			drops_seen++;
		r.out_level    = drv_level;
		r.write_strobe = strobe;
		r.busy_res     = (play_mode != MODE_IDLE);
		r.table_full   = full;
		return r;
	endfunction

	task automatic put(logic [2:0] act, logic lvl, logic [1:0] kind, logic [DUR_W-1:0] dur);
		cmd_t c;
		c.action     = act;
		c.level      = lvl;
		c.token_kind = kind;
		c.duration   = dur;
		pending_cmds.insert(pending_cmds.size(), c);
		queued++;
	endtask

	function automatic logic [DUR_W-1:0] pick_dur();
		int r;
		r = $urandom_range(99);
		if (r < 90)
			return DUR_W'($urandom_range(4));
		else if (r < 95)
			return DUR_W'($urandom_range(30, 5));
		return DUR_W'($urandom);
	endfunction

	task automatic tick();
		put(ACT_TICK, 1'($urandom_range(1)), 2'($urandom_range(3)), DUR_W'($urandom));
	endtask

	task automatic add_token();
		int         r;
		logic [1:0] kind;
		r = $urandom_range(99);
		if (r < 60)
			kind = TOK_TIMED;
		else if (r < 80)
			kind = TOK_HOLD;
		else if (r < 95)
			kind = TOK_LOOP;
		else
			kind = TOK_SPARE;
		put(ACT_ADD, 1'($urandom_range(1)), kind, pick_dur());
	endtask

	task automatic make_traffic(int target);
		int r;
		int n;
		int k;
		while (queued < target) begin
			r = $urandom_range(99);
			if (r < 60) begin
				if ($urandom_range(9) != 0)
					put(ACT_BEGIN, 1'($urandom_range(1)), 2'($urandom_range(3)),
					    DUR_W'($urandom));
				n = ($urandom_range(99) < 15) ? $urandom_range(20, 14) : $urandom_range(8, 1);
				repeat (n) add_token();
				if ($urandom_range(9) != 0)
					put(ACT_RUN, 1'($urandom_range(1)), 2'($urandom_range(3)),
					    DUR_W'($urandom));
				n = $urandom_range(40, 5);
				repeat (n) begin
					if ($urandom_range(99) < 5)
						add_token();
					else
						tick();
				end
			end else if (r < 75) begin
				put(ACT_IMPULSE, 1'($urandom_range(1)), 2'($urandom_range(3)), pick_dur());
				repeat ($urandom_range(8)) tick();
			end else if (r < 85) begin
				put(ACT_SET, 1'($urandom_range(1)), 2'($urandom_range(3)), DUR_W'($urandom));
				repeat ($urandom_range(3)) tick();
			end else if (r < 92) begin
				k = $urandom_range(2);
				if (k == 0)
					put(ACT_RUN, 1'($urandom_range(1)), 2'($urandom_range(3)),
					    DUR_W'($urandom));
				else if (k == 1)
					put(ACT_BEGIN, 1'($urandom_range(1)), 2'($urandom_range(3)),
					    DUR_W'($urandom));
				else
					tick();
			end else begin
				put(3'($urandom_range(7)), 1'($urandom_range(1)), 2'($urandom_range(3)),
				    DUR_W'($urandom));
			end
		end
	endtask

	// Input driver: a new beat is offered only once the previous one is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				expected_results.insert(expected_results.size(),
				                        blink_predict({item_ch.action, item_ch.level,
				                                       item_ch.token_kind,
				                                       item_ch.duration}));
				items_done++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle) begin
					next_cmd = pending_cmds.pop_front();
					item_ch.valid      <= 1'b1;
					item_ch.action     <= next_cmd.action;
					item_ch.level      <= next_cmd.level;
					item_ch.token_kind <= next_cmd.token_kind;
					item_ch.duration   <= next_cmd.duration;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left <= stall_left - 1;
		else if (stall_arm && !stall_done) begin
			stall_left <= STALL_LEN;
			stall_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else
			result_ch.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("result beat arrived with nothing expected");
				errors++;
			end else begin
				want = expected_results.pop_front();
				checked++;
				if (result_ch.out_level !== want.out_level) begin
					$error("out_level: expected %0d, got %0d", want.out_level,
					       result_ch.out_level);
					errors++;
				end
				if (result_ch.write_strobe !== want.write_strobe) begin
					$error("write_strobe: expected %0d, got %0d", want.write_strobe,
					       result_ch.write_strobe);
					errors++;
				end
				if (result_ch.busy_res !== want.busy_res) begin
					$error("busy_res: expected %0d, got %0d", want.busy_res,
					       result_ch.busy_res);
					errors++;
				end
				if (result_ch.table_full !== want.table_full) begin
					$error("table_full: expected %0d, got %0d", want.table_full,
					       result_ch.table_full);
					errors++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("digital_output_blink_sequencer_tb: errors");
		$finish;
	end

	initial begin
		item_ch.valid      = 1'b0;
		item_ch.action     = '0;
		item_ch.level      = 1'b0;
		item_ch.token_kind = '0;
		item_ch.duration   = '0;
		result_ch.ready    = 1'b0;
		arst_n             = 1'b0;
		drv_level          = 1'b0;
		play_mode          = MODE_IDLE;
		ticks_left         = '0;
		cur_step           = '0;
		step_count         = '0;
		loop_at            = '0;
		loop_armed         = 1'b0;
		next_high          = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		send_idle = 28;
		recv_idle = 57;
		put(ACT_RUN, 1'b0, TOK_TIMED, '0);
		put(ACT_SET, 1'b1, TOK_TIMED, '0);
		put(ACT_SET, 1'b0, TOK_TIMED, '0);
		put(ACT_TICK, 1'b0, TOK_TIMED, '0);
		put(ACT_IMPULSE, 1'b0, TOK_TIMED, '0);
		put(ACT_TICK, 1'b1, TOK_LOOP, '1);
		put(ACT_IMPULSE, 1'b0, TOK_TIMED, '1);
		put(ACT_TICK, 1'b0, TOK_TIMED, '0);
		put(ACT_SET, 1'b1, TOK_TIMED, '0);
		put(ACT_BEGIN, 1'b0, TOK_TIMED, '0);
		put(ACT_ADD, 1'b0, TOK_TIMED, 24'd2);
		put(ACT_ADD, 1'b0, TOK_HOLD, '1);
		put(ACT_ADD, 1'b0, TOK_LOOP, '0);
		put(ACT_ADD, 1'b0, TOK_TIMED, 24'd1);
		put(ACT_ADD, 1'b0, TOK_TIMED, 24'd0);
		put(ACT_ADD, 1'b0, TOK_LOOP, '0);
		put(ACT_ADD, 1'b1, TOK_SPARE, '1);
		put(ACT_RUN, 1'b0, TOK_TIMED, '0);
		repeat (6) put(ACT_TICK, 1'b0, TOK_TIMED, '0);
		put(ACT_SPARE_6, 1'b1, TOK_HOLD, '1);
		put(ACT_SPARE_7, 1'b0, TOK_LOOP, '0);
		make_traffic(500);
		while (pending_cmds.size() != 0) @(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);

		send_idle = 57;
		recv_idle = 28;
		make_traffic(1000);
		stall_arm = 1'b1;
		while (pending_cmds.size() != 0) @(negedge clk);

		send_idle = 0;
		recv_idle = 0;
		make_traffic(1500);
		while (pending_cmds.size() != 0) @(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("%0d command beats under three handshake mixes, %0d results compared",
		         items_done, checked);
		$display("%0d level writes, %0d pattern steps entered, %0d steps dropped on a full table",
		         writes_seen, steps_entered, drops_seen);
		if (errors == 0)
			$display("digital_output_blink_sequencer_tb: clean");
		else
			$display("digital_output_blink_sequencer_tb: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/dobs_pkg.sv
rtl/core/dobs_in_if.sv
rtl/core/dobs_out_if.sv
rtl/core/dobs_step_table.sv
rtl/core/dobs_engine.sv
rtl/core/digital_output_blink_sequencer.sv
tb/digital_output_blink_sequencer_tb.sv
